// ===== design/wps_pkg.sv =====
package wps_pkg;

   localparam int SqrtCells = 33;
   localparam int DivCells  = 24;

   typedef enum logic [1:0] {
      CSR_SPEED     = 2'd0,
      CSR_TOLERANCE = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] cur_x;
      logic signed [31:0] cur_y;
      logic signed [31:0] cur_z;
      logic signed [31:0] tgt_x;
      logic signed [31:0] tgt_y;
      logic signed [31:0] tgt_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] next_x;
      logic signed [31:0] next_y;
      logic signed [31:0] next_z;
      logic [32:0]        distance;
      logic               reached;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [2:0][31:0]  cur;
      logic [2:0]        neg;
      logic [2:0][32:0]  mag;
      logic [65:0]       rad;
      logic [37:0]       rem;
      logic [32:0]       root;
   } sqrt_data_type;

   typedef struct packed {
      logic              valid;
      logic [2:0][31:0]  cur;
      logic [2:0]        neg;
      logic [32:0]       dvsr;
      logic [2:0][23:0]  low;
      logic [2:0][32:0]  rem;
      logic [2:0][23:0]  quo;
   } div_data_type;

endpackage

// ===== design/wps_sqrt_cell.sv =====
module wps_sqrt_cell
   import wps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  sqrt_data_type din,
   output sqrt_data_type dout
);

   sqrt_data_type data_ff, data_in;
   logic [37:0] rem_sh, trial;

   always_comb begin
      rem_sh  = {din.rem[35:0], din.rad[65:64]};
      trial   = {3'b000, din.root, 2'b01};
      data_in = din;
      data_in.rad = {din.rad[63:0], 2'b00};
      if (rem_sh >= trial) begin
         data_in.rem  = rem_sh - trial;
         data_in.root = {din.root[31:0], 1'b1};
      end else begin
         data_in.rem  = rem_sh;
         data_in.root = {din.root[31:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (en) begin
         data_ff <= data_in;
      end
   end

   assign dout = data_ff;

endmodule

// ===== design/wps_div_cell.sv =====
module wps_div_cell
   import wps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  div_data_type din,
   output div_data_type dout
);

   div_data_type data_ff, data_in;
   logic [2:0][33:0] rem_sh;

   always_comb begin
      data_in = din;
      for (int l = 0; l < 3; l++) begin
         rem_sh[l] = {din.rem[l], din.low[l][23]};
         data_in.low[l] = {din.low[l][22:0], 1'b0};
         if (rem_sh[l] >= {1'b0, din.dvsr}) begin
            data_in.rem[l] = 33'(rem_sh[l] - {1'b0, din.dvsr});
            data_in.quo[l] = {din.quo[l][22:0], 1'b1};
         end else begin
            data_in.rem[l] = rem_sh[l][32:0];
            data_in.quo[l] = {din.quo[l][22:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (en) begin
         data_ff <= data_in;
      end
   end

   assign dout = data_ff;

endmodule

// ===== design/waypoint_step_3d.sv =====
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req_data (req_type)
// result  | rsp_valid | rsp_stall | rsp_data (rsp_type)
// csr     | csr_we    | -         | csr_index, csr_wdata
// One transfer per cycle while the result is not stalled; stages: 3 front stages, 33 square-root
// cells (two radicand bits each), 1 multiply stage, 24 divider cells, output.
// The whole pipeline holds while the result register is full and stalled.
// Synchronous reset clears all valid bits and loads speed and tolerance.
module waypoint_step_3d
   import wps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   logic [23:0] speed_ff, tolerance_ff;
   logic        adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= 24'd65536;
         tolerance_ff <= 24'd32768;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED:     speed_ff     <= csr_wdata;
            CSR_TOLERANCE: tolerance_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // front: differences, squares, sum
   logic                    a_valid_ff, b_valid_ff, c_valid_ff;
   logic [2:0][31:0]        a_cur_ff, b_cur_ff, c_cur_ff;
   logic [2:0][32:0]        a_delta_ff, b_mag_ff, c_mag_ff;
   logic [2:0]              b_neg_ff, c_neg_ff;
   logic [2:0][65:0]        b_sq_ff;
   logic [65:0]             c_sum_ff;
   logic [2:0][31:0]        in_cur, in_tgt;
   logic [2:0][32:0]        abs_d;

   assign in_cur = {req_data.cur_x, req_data.cur_y, req_data.cur_z};
   assign in_tgt = {req_data.tgt_x, req_data.tgt_y, req_data.tgt_z};

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         abs_d[l] = a_delta_ff[l][32] ? 33'(-a_delta_ff[l]) : a_delta_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         a_cur_ff   <= in_cur;
         b_cur_ff   <= a_cur_ff;
         c_cur_ff   <= b_cur_ff;
         b_mag_ff   <= abs_d;
         c_mag_ff   <= b_mag_ff;
         c_neg_ff   <= b_neg_ff;
         for (int l = 0; l < 3; l++) begin
            a_delta_ff[l] <= {in_tgt[l][31], in_tgt[l]} - {in_cur[l][31], in_cur[l]};
            b_neg_ff[l]   <= a_delta_ff[l][32];
            b_sq_ff[l]    <= 66'(abs_d[l][31:0]) * 66'(abs_d[l][31:0]);
         end
         c_sum_ff <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
      end
   end

   // square-root chain
   sqrt_data_type sq [SqrtCells+1];

   always_comb begin
      sq[0]       = '0;
      sq[0].valid = c_valid_ff;
      sq[0].cur   = c_cur_ff;
      sq[0].neg   = c_neg_ff;
      sq[0].mag   = c_mag_ff;
      sq[0].rad   = c_sum_ff;
   end

   for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
      wps_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (adv),
         .din   (sq[i]),
         .dout  (sq[i+1])
      );
   end

   // multiply |delta| by speed
   logic             m_valid_ff;
   logic [2:0][31:0] m_cur_ff;
   logic [2:0]       m_neg_ff;
   logic [32:0]      m_dist_ff;
   logic [2:0][56:0] m_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= sq[SqrtCells].valid;
         m_cur_ff   <= sq[SqrtCells].cur;
         m_neg_ff   <= sq[SqrtCells].neg;
         m_dist_ff  <= sq[SqrtCells].root;
         for (int l = 0; l < 3; l++) begin
            m_num_ff[l] <= 57'(sq[SqrtCells].mag[l]) * 57'(speed_ff);
         end
      end
   end

   // divider chain
   div_data_type dv [DivCells+1];

   always_comb begin
      dv[0]       = '0;
      dv[0].valid = m_valid_ff;
      dv[0].cur   = m_cur_ff;
      dv[0].neg   = m_neg_ff;
      dv[0].dvsr  = m_dist_ff;
      for (int l = 0; l < 3; l++) begin
         dv[0].rem[l] = m_num_ff[l][56:24];
         dv[0].low[l] = m_num_ff[l][23:0];
      end
   end

   for (genvar i = 0; i < DivCells; i++) begin : g_div
      wps_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (adv),
         .din   (dv[i]),
         .dout  (dv[i+1])
      );
   end

   // step, saturating add, result register
   div_data_type     fin;
   logic [2:0][32:0] sum;
   logic [2:0][31:0] next;
   logic [2:0][32:0] step;
   rsp_type          rsp_ff;

   assign fin = dv[DivCells];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (fin.dvsr == '0) begin
            step[l] = '0;
         end else if (fin.neg[l]) begin
            step[l] = 33'(-{9'b0, fin.quo[l]});
         end else begin
            step[l] = {9'b0, fin.quo[l]};
         end
         sum[l] = {fin.cur[l][31], fin.cur[l]} + step[l];
         if (sum[l][32] != sum[l][31]) begin
            next[l] = sum[l][32] ? 32'h8000_0000 : 32'h7fff_ffff;
         end else begin
            next[l] = sum[l][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff    <= fin.valid;
         rsp_ff.next_x   <= next[2];
         rsp_ff.next_y   <= next[1];
         rsp_ff.next_z   <= next[0];
         rsp_ff.distance <= fin.dvsr;
         rsp_ff.reached  <= fin.dvsr < {9'b0, tolerance_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/tb_waypoint_step_3d.sv =====
module tb_waypoint_step_3d;
   import wps_pkg::*;

   localparam logic [1:0] CsrUnused = 2'd3;
   localparam int Latency = 62;
   localparam int CycleLimit = 400000;
   localparam int RandPerPhase = 250;
   localparam int NumPhases = 7;

   typedef struct {
      req_type d;
      bit      known;
      rsp_type e;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [23:0] csr_wdata = '0;

   logic [23:0] speed_reg = 24'd65536;
   logic [23:0] tol_reg = 24'd32768;
   rsp_type     pending_steps[$];
   int          cycle_count = 0;
   bit          failed = 1'b0;
   dir_row_type dir_rows[$];

   waypoint_step_3d u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic rsp_type predict_step(req_type r, logic [23:0] spd, logic [23:0] tol);
      logic signed [31:0] c[3];
      logic signed [31:0] t[3];
      longint d[3];
      logic [32:0] mg[3];
      logic [67:0] sumsq;
      logic [67:0] sq;
      logic [33:0] root;
      logic [33:0] cand;
      logic [56:0] q;
      longint v;
      logic [31:0] nxt[3];
      rsp_type res;
      c = '{r.cur_x, r.cur_y, r.cur_z};
      t = '{r.tgt_x, r.tgt_y, r.tgt_z};
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'(t[i]) - longint'(c[i]);
         mg[i] = 33'(d[i] < 0 ? -d[i] : d[i]);
         sumsq = sumsq + 68'(mg[i]) * 68'(mg[i]);
      end
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = root | (34'd1 << b);
         sq = 68'(cand) * 68'(cand);
         if (sq <= sumsq) root = cand;
      end
      for (int i = 0; i < 3; i++) begin
         if (root == 0) q = '0;
         else q = (57'(mg[i]) * 57'(spd)) / 57'(root);
         v = longint'(c[i]) + (d[i] < 0 ? -longint'(q) : longint'(q));
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         nxt[i] = v[31:0];
      end
      res.next_x = nxt[0];
      res.next_y = nxt[1];
      res.next_z = nxt[2];
      res.distance = root[32:0];
      res.reached = (root < 34'(tol));
      return res;
   endfunction

   function automatic req_type mk_req(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                      logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
      req_type r;
      r.cur_x = cx; r.cur_y = cy; r.cur_z = cz;
      r.tgt_x = tx; r.tgt_y = ty; r.tgt_z = tz;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                      logic [32:0] dlen, logic rch);
      rsp_type e;
      e.next_x = nx; e.next_y = ny; e.next_z = nz;
      e.distance = dlen; e.reached = rch;
      return e;
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] near_coord(logic [31:0] base);
      case ($urandom_range(0, 3))
         0: return base;
         1: return base + 32'($urandom_range(0, 255)) - 32'd128;
         2: return base + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
         default: return base + 32'($urandom_range(0, 1 << 26)) - 32'(1 << 25);
      endcase
   endfunction

   function automatic req_type rand_req();
      req_type r;
      case ($urandom_range(0, 9))
         0, 1, 2: r = mk_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         3, 4: r = mk_req(pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), pick_coord(), pick_coord());
         5: begin
            r = mk_req($urandom, $urandom, $urandom, 0, 0, 0);
            r.tgt_x = r.cur_x; r.tgt_y = r.cur_y; r.tgt_z = r.cur_z;
         end
         6: begin
            r = mk_req(pick_coord(), pick_coord(), pick_coord(), 0, 0, 0);
            r.tgt_x = near_coord(r.cur_x);
            r.tgt_y = near_coord(r.cur_y);
            r.tgt_z = near_coord(r.cur_z);
         end
         default: begin
            r = mk_req($urandom, $urandom, $urandom, 0, 0, 0);
            r.tgt_x = near_coord(r.cur_x);
            r.tgt_y = near_coord(r.cur_y);
            r.tgt_z = near_coord(r.cur_z);
         end
      endcase
      return r;
   endfunction

   task automatic send_item(req_type d, bit known, rsp_type e);
      req_valid <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (req_stall);
      pending_steps.push_back(known ? e : predict_step(d, speed_reg, tol_reg));
   endtask

   task automatic idle_gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic write_regs(logic [23:0] spd, logic [23:0] tol);
      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (Latency + 8) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_SPEED;
      csr_wdata <= spd;
      @(posedge clock);
      csr_index <= CSR_TOLERANCE;
      csr_wdata <= tol;
      @(posedge clock);
      csr_index <= CsrUnused;
      csr_wdata <= 24'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      speed_reg = spd;
      tol_reg = tol;
   endtask

   // sender
   initial begin
      int burst;
      rsp_type none;
      none = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_rows.push_back('{mk_req(0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 1)});
      dir_rows.push_back('{mk_req(0, 0, 0, 32'h10000, 0, 0), 1,
                           mk_rsp(32'h10000, 0, 0, 33'h10000, 0)});
      dir_rows.push_back('{mk_req(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0), 1,
                           mk_rsp(32'h7FFE_FFFF, 0, 0, 33'hFFFF_FFFF, 0)});
      dir_rows.push_back('{mk_req(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0), 1,
                           mk_rsp(32'h8001_0000, 0, 0, 33'hFFFF_FFFF, 0)});
      dir_rows.push_back('{mk_req(0, 0, 0, 0, 32'd32767, 0), 1,
                           mk_rsp(0, 32'h10000, 0, 33'd32767, 1)});
      dir_rows.push_back('{mk_req(0, 0, 0, 0, 0, 32'd32768), 1,
                           mk_rsp(0, 0, 32'h10000, 33'd32768, 0)});
      dir_rows.push_back('{mk_req(5, -7, 9, 5, -7, 9), 1, mk_rsp(5, -7, 9, 0, 1)});
      dir_rows.push_back('{mk_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, none});
      dir_rows.push_back('{mk_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, none});
      dir_rows.push_back('{mk_req(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF,
                                  0, 32'hFFFF_FFFF, 32'h8000_0000), 0, none});
      dir_rows.push_back('{mk_req(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                                  32'hEDCB_A987, 32'h6543_2110, 32'hF0F0_F0F0), 0, none});
      dir_rows.push_back('{mk_req(0, 0, 0, 1, 1, 1), 0, none});
      dir_rows.push_back('{mk_req(0, 0, 0, -1, 2, -3), 0, none});
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].d, dir_rows[i].known, dir_rows[i].e);
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 4));
      end

      for (int p = 0; p < NumPhases; p++) begin
         case (p)
            0: write_regs(24'h0, 24'h0);
            1: write_regs(24'hFF_FFFF, 24'hFF_FFFF);
            2: write_regs(24'h1, 24'hFF_FFFF);
            3: write_regs(24'h10000, 24'h0);
            default: write_regs(24'($urandom), 24'($urandom));
         endcase
         if (p == 1) begin
            // overshoot past the range limits
            send_item(mk_req(32'h7FFF_FFF0, 32'h8000_0010, 0,
                             32'h7FFF_FFFF, 32'h8000_0000, 0), 0, none);
            send_item(mk_req(32'h7FFF_0000, 32'h8000_8000, 32'h7FFF_FFFE,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0, none);
         end
         for (int n = 0; n < RandPerPhase; ) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n < RandPerPhase; k++, n++)
               send_item(rand_req(), 0, none);
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 10));
         end
      end

      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (Latency + 8) @(posedge clock);
      if (!failed) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // receiver stall pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case (cycle_count[9:7])
         0, 1: rsp_stall <= 1'b0;
         2, 3, 4: rsp_stall <= ($urandom_range(0, 3) == 0);
         5: rsp_stall <= $urandom_range(0, 1);
         6: rsp_stall <= (cycle_count[4:0] < 20);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result check
   always @(posedge clock) begin
      rsp_type e;
      bit      bad;
      bad = 1'b0;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_steps.size() == 0) begin
            $display("%0t: unexpected transfer %h", $time, rsp_data);
            bad = 1'b1;
         end else begin
            e = pending_steps.pop_front();
            if (rsp_data.next_x !== e.next_x) begin
               $display("%0t: next_x exp %h got %h", $time, e.next_x, rsp_data.next_x);
               bad = 1'b1;
            end
            if (rsp_data.next_y !== e.next_y) begin
               $display("%0t: next_y exp %h got %h", $time, e.next_y, rsp_data.next_y);
               bad = 1'b1;
            end
            if (rsp_data.next_z !== e.next_z) begin
               $display("%0t: next_z exp %h got %h", $time, e.next_z, rsp_data.next_z);
               bad = 1'b1;
            end
            if (rsp_data.distance !== e.distance) begin
               $display("%0t: distance exp %h got %h", $time, e.distance, rsp_data.distance);
               bad = 1'b1;
            end
            if (rsp_data.reached !== e.reached) begin
               $display("%0t: reached exp %b got %b", $time, e.reached, rsp_data.reached);
               bad = 1'b1;
            end
         end
      end
      if (bad) failed <= 1'b1;
   end

endmodule
